[rtl/fqs_pkg.sv]
// ----------------------------------------------------------------------------
// fqs_pkg
// Shared types and constants for the FIFO queue with first-match search.
// ----------------------------------------------------------------------------
package fqs_pkg;

   localparam int KIND_W  = 2;
   localparam int VALUE_W = 32;
   localparam int FIELD_W = 5;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH   = 2'd0,
      KIND_POP    = 2'd1,
      KIND_SEARCH = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctl_type;

endpackage

[rtl/fqs_cell.sv]
// ----------------------------------------------------------------------------
// fqs_cell
// One queue slot: holds a value and its valid bit, shifts toward the head on
// pop, loads the pushed value when it is the first free slot, compares to key.
// ----------------------------------------------------------------------------
module fqs_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  fqs_pkg::cell_ctl_type               ctl,
   input  logic signed [fqs_pkg::VALUE_W-1:0]  load_value,
   input  logic                                next_valid,
   input  logic signed [fqs_pkg::VALUE_W-1:0]  next_data,
   input  logic signed [fqs_pkg::VALUE_W-1:0]  key,
   output logic                                valid,
   output logic signed [fqs_pkg::VALUE_W-1:0]  data,
   output logic                                match
);

   logic                               valid_ff;
   logic                               valid_in;
   logic signed [fqs_pkg::VALUE_W-1:0] data_ff;
   logic signed [fqs_pkg::VALUE_W-1:0] data_in;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (ctl.shift) begin
         valid_in = next_valid;
         data_in  = next_data;
      end else if (ctl.load) begin
         valid_in = 1'b1;
         data_in  = load_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign valid = valid_ff;
   assign data  = data_ff;
   assign match = valid_ff && (data_ff == key);

endmodule

[rtl/fqs_find.sv]
// ----------------------------------------------------------------------------
// fqs_find
// First-match encoder: 1-based position of the lowest set match bit.
// ----------------------------------------------------------------------------
module fqs_find #(
   parameter int DEPTH = 16
) (
   input  logic [DEPTH-1:0]               match,
   output logic                           found,
   output logic [$clog2(DEPTH+1)-1:0]     position
);

   localparam int POS_W = $clog2(DEPTH + 1);

   always_comb begin
      position = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (match[i]) begin
            position = POS_W'(i + 1);
         end
      end
   end

   assign found = |match;

endmodule

[rtl/fifo_queue_with_search.sv]
// ----------------------------------------------------------------------------
// fifo_queue_with_search
// FIFO queue of signed 32-bit values held in a row of shifting cells, head in
// cell 0, with push, pop and first-match search.
// The result strobe is registered: it rises in the cycle after the item is accepted.
// Throughput: one item per cycle; busy stays low, every cell updates and
// compares against the key in the same cycle.
// Reset: empties the queue and clears the result strobe; stored values are
// left as they are.
// ----------------------------------------------------------------------------
module fifo_queue_with_search #(
   parameter int DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [fqs_pkg::KIND_W-1:0]          req_kind,
   input  logic signed [fqs_pkg::VALUE_W-1:0]  req_value,
   output logic                                rsp_strobe,
   output logic [1:0]                          rsp_status,
   output logic signed [fqs_pkg::VALUE_W-1:0]  rsp_data,
   output logic [fqs_pkg::FIELD_W-1:0]         rsp_position,
   output logic [fqs_pkg::FIELD_W-1:0]         rsp_count
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic                               accept;
   logic                               full;
   logic                               empty;
   logic                               push_ok;
   logic                               pop_ok;
   logic [CNT_W-1:0]                   count_ff;
   logic [CNT_W-1:0]                   count_in;
   logic [DEPTH-1:0]                   cell_valid;
   logic [DEPTH-1:0]                   cell_match;
   logic signed [fqs_pkg::VALUE_W-1:0] cell_data [DEPTH];
   fqs_pkg::cell_ctl_type              cell_ctl [DEPTH];
   logic                               found;
   logic [CNT_W-1:0]                   found_pos;

   logic                               rsp_strobe_ff;
   logic                               rsp_strobe_in;
   fqs_pkg::status_type                rsp_status_ff;
   fqs_pkg::status_type                rsp_status_in;
   logic signed [fqs_pkg::VALUE_W-1:0] rsp_data_ff;
   logic signed [fqs_pkg::VALUE_W-1:0] rsp_data_in;
   logic [fqs_pkg::FIELD_W-1:0]        rsp_position_ff;
   logic [fqs_pkg::FIELD_W-1:0]        rsp_position_in;
   logic [fqs_pkg::FIELD_W-1:0]        rsp_count_ff;
   logic [fqs_pkg::FIELD_W-1:0]        rsp_count_in;

   assign busy    = 1'b0;
   assign accept  = start && !busy;
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign push_ok = accept && (req_kind == fqs_pkg::KIND_PUSH) && !full;
   assign pop_ok  = accept && (req_kind == fqs_pkg::KIND_POP) && !empty;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                               nxt_valid;
      logic signed [fqs_pkg::VALUE_W-1:0] nxt_data;

      if (i == DEPTH - 1) begin : g_tail
         assign nxt_valid = 1'b0;
         assign nxt_data  = '0;
      end else begin : g_mid
         assign nxt_valid = cell_valid[i+1];
         assign nxt_data  = cell_data[i+1];
      end

      assign cell_ctl[i].shift = pop_ok;
      assign cell_ctl[i].load  = push_ok && (count_ff == CNT_W'(i));

      fqs_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (cell_ctl[i]),
         .load_value (req_value),
         .next_valid (nxt_valid),
         .next_data  (nxt_data),
         .key        (req_value),
         .valid      (cell_valid[i]),
         .data       (cell_data[i]),
         .match      (cell_match[i])
      );
   end

   fqs_find #(
      .DEPTH (DEPTH)
   ) u_find (
      .match    (cell_match),
      .found    (found),
      .position (found_pos)
   );

   always_comb begin
      count_in = count_ff;
      if (push_ok) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop_ok) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      rsp_strobe_in   = accept;
      rsp_status_in   = fqs_pkg::ST_OK;
      rsp_data_in     = '0;
      rsp_position_in = '0;
      rsp_count_in    = fqs_pkg::FIELD_W'(count_in);
      case (req_kind)
         fqs_pkg::KIND_PUSH: begin
            if (full) begin
               rsp_status_in = fqs_pkg::ST_FULL;
            end
         end
         fqs_pkg::KIND_POP: begin
            if (empty) begin
               rsp_status_in = fqs_pkg::ST_EMPTY;
            end else begin
               rsp_data_in = cell_data[0];
            end
         end
         fqs_pkg::KIND_SEARCH: begin
            if (found) begin
               rsp_position_in = fqs_pkg::FIELD_W'(found_pos);
            end else begin
               rsp_status_in = fqs_pkg::ST_NOT_FOUND;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff   <= rsp_status_in;
         rsp_data_ff     <= rsp_data_in;
         rsp_position_ff <= rsp_position_in;
         rsp_count_ff    <= rsp_count_in;
      end
   end

   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_data     = rsp_data_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_count    = rsp_count_ff;

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the FIFO queue with first-match search. A queue of
// pending items feeds a clocked driver; an in-bench queue model predicts each
// result, and a clocked monitor compares every strobed result field by field.
// Directed items cover empty, duplicate and extreme-value cases, then
// random fill and drain bursts run under several sender idling phases.
// ----------------------------------------------------------------------------
module tb;

   localparam int QUEUE_DEPTH = 16;
   localparam int BURST_LEN = 24;
   localparam int ITEMS_PER_PHASE = 175;
   localparam logic [fqs_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam logic signed [fqs_pkg::VALUE_W-1:0] VALUE_POOL [6] = '{
      32'sh0000_0000, 32'shFFFF_FFFF, 32'sh8000_0000,
      32'sh7FFF_FFFF, 32'sh5A5A_A5A5, 32'sh0000_0001
   };
   localparam int IDLE_PLAN [4] = '{0, 55, 0, 26};

   typedef struct packed {
      logic [fqs_pkg::KIND_W-1:0]         kind;
      logic signed [fqs_pkg::VALUE_W-1:0] value;
   } queue_op_type;

   typedef struct {
      fqs_pkg::status_type                status;
      logic signed [fqs_pkg::VALUE_W-1:0] data;
      logic [fqs_pkg::FIELD_W-1:0]        position;
      logic [fqs_pkg::FIELD_W-1:0]        count;
   } queue_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [fqs_pkg::KIND_W-1:0] req_kind = '0;
   logic signed [fqs_pkg::VALUE_W-1:0] req_value = '0;
   logic rsp_strobe;
   logic [1:0] rsp_status;
   logic signed [fqs_pkg::VALUE_W-1:0] rsp_data;
   logic [fqs_pkg::FIELD_W-1:0] rsp_position;
   logic [fqs_pkg::FIELD_W-1:0] rsp_count;

   queue_op_type pending_ops[$];
   queue_rsp_type expected_rsps[$];
   logic signed [fqs_pkg::VALUE_W-1:0] held_values[$];
   int send_idle_pct = 0;
   int accepted_ops = 0;
   int queued_ops = 0;
   int fail_count = 0;

   fifo_queue_with_search #(.DEPTH(QUEUE_DEPTH)) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_kind(req_kind),
      .req_value(req_value),
      .rsp_strobe(rsp_strobe),
      .rsp_status(rsp_status),
      .rsp_data(rsp_data),
      .rsp_position(rsp_position),
      .rsp_count(rsp_count)
   );

   always #10 clock = ~clock;

   function automatic queue_rsp_type apply_queue_op(
      logic [fqs_pkg::KIND_W-1:0] kind,
      logic signed [fqs_pkg::VALUE_W-1:0] value);
      queue_rsp_type rsp;
      rsp.status = fqs_pkg::ST_OK;
      rsp.data = '0;
      rsp.position = '0;
      case (kind)
         fqs_pkg::KIND_PUSH: begin
            if (held_values.size() >= QUEUE_DEPTH) rsp.status = fqs_pkg::ST_FULL;
            else held_values.push_back(value);
         end
         fqs_pkg::KIND_POP: begin
            if (held_values.size() == 0) rsp.status = fqs_pkg::ST_EMPTY;
            else rsp.data = held_values.pop_front();
         end
         fqs_pkg::KIND_SEARCH: begin
            rsp.status = fqs_pkg::ST_NOT_FOUND;
            foreach (held_values[i]) begin
               if (rsp.status == fqs_pkg::ST_NOT_FOUND && held_values[i] == value) begin
                  rsp.status = fqs_pkg::ST_OK;
                  rsp.position = fqs_pkg::FIELD_W'(i + 1);
               end
            end
         end
         default: ;
      endcase
      rsp.count = fqs_pkg::FIELD_W'(held_values.size());
      return rsp;
   endfunction

   function automatic queue_op_type random_op(bit filling);
      queue_op_type op;
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) op.kind = KIND_UNUSED;
      else if (r < 25) op.kind = fqs_pkg::KIND_SEARCH;
      else if (r < (filling ? 85 : 45)) op.kind = fqs_pkg::KIND_PUSH;
      else op.kind = fqs_pkg::KIND_POP;
      if ($urandom_range(0, 99) < 60) op.value = VALUE_POOL[$urandom_range(0, 5)];
      else op.value = $urandom;
      return op;
   endfunction

   task automatic add_op(logic [fqs_pkg::KIND_W-1:0] kind,
                         logic signed [fqs_pkg::VALUE_W-1:0] value);
      queue_op_type op;
      op.kind = kind;
      op.value = value;
      pending_ops.push_back(op);
      queued_ops++;
   endtask

   task automatic check_field(string name, logic [fqs_pkg::VALUE_W-1:0] exp_val,
                              logic [fqs_pkg::VALUE_W-1:0] act_val);
      if (act_val !== exp_val) begin
         $error("%s mismatch: expected %0h, got %0h", name, exp_val, act_val);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : driver
      queue_op_type op;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_rsps.push_back(apply_queue_op(req_kind, req_value));
            accepted_ops++;
         end
         if (!(start && busy)) begin
            if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               op = pending_ops.pop_front();
               req_kind <= op.kind;
               req_value <= op.value;
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      queue_rsp_type exp_rsp;
      if (!reset && rsp_strobe) begin
         if (expected_rsps.size() == 0) begin
            $error("result strobed with no item outstanding");
            fail_count++;
         end else begin
            exp_rsp = expected_rsps.pop_front();
            check_field("status", fqs_pkg::VALUE_W'(exp_rsp.status),
                        fqs_pkg::VALUE_W'(rsp_status));
            check_field("data", exp_rsp.data, rsp_data);
            check_field("position", fqs_pkg::VALUE_W'(exp_rsp.position),
                        fqs_pkg::VALUE_W'(rsp_position));
            check_field("count", fqs_pkg::VALUE_W'(exp_rsp.count),
                        fqs_pkg::VALUE_W'(rsp_count));
         end
      end
   end

   initial begin : stimulus
      bit filling;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      add_op(fqs_pkg::KIND_POP, 32'sh1234_5678);
      add_op(fqs_pkg::KIND_SEARCH, 32'sh0000_0000);
      add_op(KIND_UNUSED, 32'sh0000_0000);
      add_op(fqs_pkg::KIND_PUSH, 32'sh8000_0000);
      add_op(fqs_pkg::KIND_PUSH, 32'sh7FFF_FFFF);
      add_op(fqs_pkg::KIND_PUSH, 32'sh0000_0000);
      add_op(fqs_pkg::KIND_PUSH, 32'shFFFF_FFFF);
      add_op(fqs_pkg::KIND_PUSH, 32'sh0000_0007);
      add_op(fqs_pkg::KIND_PUSH, 32'sh0000_0007);
      add_op(fqs_pkg::KIND_SEARCH, 32'sh0000_0007);
      add_op(fqs_pkg::KIND_SEARCH, 32'sh8000_0000);
      add_op(fqs_pkg::KIND_SEARCH, 32'shFFFF_FFFF);
      add_op(fqs_pkg::KIND_SEARCH, 32'sh0001_E240);
      add_op(KIND_UNUSED, 32'shFFFF_FFFF);
      add_op(fqs_pkg::KIND_POP, 32'shFFFF_FFFF);
      add_op(fqs_pkg::KIND_SEARCH, 32'sh7FFF_FFFF);
      repeat (5) add_op(fqs_pkg::KIND_POP, 32'sh0000_0000);
      add_op(fqs_pkg::KIND_POP, 32'sh0000_0000);

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = IDLE_PLAN[phase];
         filling = 1'b1;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n % BURST_LEN == 0 && n != 0) filling = $urandom_range(0, 1);
            pending_ops.push_back(random_op(filling));
            queued_ops++;
         end
         while (accepted_ops < queued_ops) @(posedge clock);
      end

      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #(20 * 200000);
      $display("Regression FAIL");
      $finish;
   end

endmodule

[files.f]
rtl/fqs_pkg.sv
rtl/fqs_cell.sv
rtl/fqs_find.sv
rtl/fifo_queue_with_search.sv
verif/tb.sv
